@@ rtl/pool_free_list_allocator_defines.svh @@
// ----------------------------------------------------------------------------
// pool_free_list_allocator_defines
// Assertion macros shared by the pool allocator RTL.
// ----------------------------------------------------------------------------
`ifndef POOL_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define POOL_FREE_LIST_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PFL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("pool allocator assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define PFL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("pool allocator assertion failed");

`endif

@@ rtl/pfl_pkg.sv @@
// ----------------------------------------------------------------------------
// pfl_pkg
// Field widths, command codes and register indexes of the pool allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pfl_pkg;

  // Payload field widths.
  localparam int unsigned SLOT_W     = 8;
  localparam int unsigned OFFSET_W   = 20;
  localparam int unsigned COUNT_W    = 9;
  localparam int unsigned CHUNK_W    = 13;
  localparam int unsigned INIT_W     = 9;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 13;

  // Commands.
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_BYTES   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_SLOTS = 1'd1;

  // Register values after reset.
  localparam logic [CHUNK_W-1:0] CHUNK_RESET = 13'd64;
  localparam logic [INIT_W-1:0]  INIT_RESET  = 9'd16;

endpackage

`default_nettype wire

@@ rtl/pfl_if.sv @@
// ----------------------------------------------------------------------------
// pfl_if
// Valid/ready channels of the pool allocator: request, result and
// configuration write.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfl_in_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [pfl_pkg::SLOT_W-1:0]  slot;

  modport source (output valid, output cmd, output slot, input ready);
  modport sink   (input valid, input cmd, input slot, output ready);
endinterface

interface pfl_out_if;
  logic                          valid;
  logic                          ready;
  logic [pfl_pkg::SLOT_W-1:0]    granted_slot;
  logic [pfl_pkg::OFFSET_W-1:0]  granted_offset;
  logic                          ok;
  logic [pfl_pkg::COUNT_W-1:0]   free_count;
  logic [pfl_pkg::COUNT_W-1:0]   pool_capacity;

  modport source (output valid, output granted_slot, output granted_offset, output ok,
                  output free_count, output pool_capacity, input ready);
  modport sink   (input valid, input granted_slot, input granted_offset, input ok,
                  input free_count, input pool_capacity, output ready);
endinterface

interface pfl_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [pfl_pkg::CFG_IDX_W-1:0]    idx;
  logic [pfl_pkg::CFG_DATA_W-1:0]   wdata;

  modport source (output valid, output idx, output wdata, input ready);
  modport sink   (input valid, input idx, input wdata, output ready);
endinterface

`default_nettype wire

@@ rtl/pool_free_list_allocator.sv @@
// ----------------------------------------------------------------------------
// pool_free_list_allocator
// Fixed-size slot pool with a LIFO free list kept in a next-link memory.
// ----------------------------------------------------------------------------
// Usage: a request on in_i (cmd, slot) allocates the head slot or pushes the
// given slot; each request yields one result transfer on out_o with the
// granted slot, its byte offset, a success flag and the pool counters.
// cfg_i writes chunk_bytes (index 0) or initial_slots (index 1); writing
// initial_slots rebuilds the free list, like reset does.
// Sequencing: a free is handled in the idle state, an allocate passes
// through the read state (registered read of the next-link memory), and an
// allocate that grows the pool stays in the grow state while the single write
// port of the next-link memory links one new slot per cycle. Each result is
// registered and valid in the cycle after the last of these states.
// Reset: the block links slots 0 to initial_slots-1 (16 by default), one
// per cycle, and holds in_i.ready low until that sweep ends. A write of
// initial_slots starts the same sweep, unless the clamped count is zero.
// Stall: the result sits in an output register; a new request is taken only
// once that register is empty or is drained in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "pool_free_list_allocator_defines.svh"

module pool_free_list_allocator #(
  parameter int unsigned SLOTS = 256
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  pfl_cfg_if.sink     cfg_i,
  pfl_in_if.sink      in_i,
  pfl_out_if.source   out_o
);

  localparam int unsigned IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CW    = $clog2(SLOTS + 1);
  localparam int unsigned SlotW = pfl_pkg::SLOT_W;
  localparam int unsigned CntW  = pfl_pkg::COUNT_W;
  localparam int unsigned OffW  = pfl_pkg::OFFSET_W;
  localparam int unsigned ChkW  = pfl_pkg::CHUNK_W;
  localparam int unsigned InitN = (32'(pfl_pkg::INIT_RESET) > SLOTS) ? SLOTS
                                                                    : 32'(pfl_pkg::INIT_RESET);
  localparam logic [CW-1:0] SlotsCnt = CW'(SLOTS);

  // Sequencer states.
  localparam logic [1:0] ST_INIT = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_GROW = 2'd3;

  logic [1:0]                   state_q, state_d;
  logic [ChkW-1:0]              chunk_q, chunk_d;
  logic [pfl_pkg::INIT_W-1:0]   init_q, init_d;
  logic [IW-1:0]                head_q, head_d;
  logic [CW-1:0]                free_q, free_d;
  logic [CW-1:0]                cap_q, cap_d;
  logic [CW-1:0]                grow_q, grow_d;
  logic [IW-1:0]                run_ptr_q, run_ptr_d;
  logic [IW-1:0]                run_last_q, run_last_d;

  // Next-link memory, one write and one registered read per cycle.
  logic [IW-1:0]                link_mem [SLOTS];
  logic [IW-1:0]                rdata_q;
  logic                         mem_we;
  logic [IW-1:0]                mem_waddr;
  logic [IW-1:0]                mem_wdata;

  // Output register.
  logic                         out_valid_q;
  logic [SlotW-1:0]             out_slot_q;
  logic [OffW-1:0]              out_off_q;
  logic                         out_ok_q;
  logic [CntW-1:0]              out_free_q;
  logic [CntW-1:0]              out_cap_q;

  logic                         load_en;
  logic [IW-1:0]                load_slot;
  logic                         load_ok;
  logic [CW-1:0]                load_free;
  logic [CW-1:0]                load_cap;
  logic [SlotW-1:0]             load_slot8;
  logic [SlotW+ChkW-1:0]        load_prod;

  logic                         in_acc;
  logic                         cfg_acc;
  logic                         alloc_acc;
  logic                         free_acc;
  logic [IW-1:0]                slot_wrap;
  logic [IW-1:0]                wrap_tbl [256];
  logic [IW-1:0]                run_link;
  logic [CW:0]                  grow_raw;
  logic [CW-1:0]                grow_min;
  logic [CW-1:0]                room;
  logic [CW-1:0]                grow_cnt;
  logic [CW-1:0]                free_inc;
  logic [CW-1:0]                cfg_n;

  // Handshakes.
  assign in_i.ready  = (state_q == ST_IDLE) && (!out_valid_q || out_o.ready);
  assign cfg_i.ready = 1'b1;
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;
  assign alloc_acc   = in_acc && (in_i.cmd == pfl_pkg::CMD_ALLOC);
  assign free_acc    = in_acc && !cfg_acc && (in_i.cmd == pfl_pkg::CMD_FREE);

  // Slot index taken modulo SLOTS through a constant table.
  for (genvar g = 0; g < 256; g++) begin : g_wrap
    assign wrap_tbl[g] = IW'(g % SLOTS);
  end
  assign slot_wrap = wrap_tbl[in_i.slot];

  // Link value written while sweeping a run of consecutive slots.
  assign run_link = (run_ptr_q == run_last_q) ? '0 : run_ptr_q + IW'(1);

  // Growth size: capacity times 1.5, at least one, capped by the room left.
  assign grow_raw = {1'b0, cap_q} + (CW+1)'(cap_q >> 1);
  assign grow_min = (grow_raw == '0) ? CW'(1) : CW'(grow_raw);
  assign room     = SlotsCnt - cap_q;
  assign grow_cnt = ((grow_raw > (CW+1)'(room)) || (grow_min > room)) ? room : grow_min;

  // Saturating count for a free.
  assign free_inc = (free_q < SlotsCnt) ? free_q + CW'(1) : free_q;

  // Clamped initial slot count of a configuration write.
  assign cfg_n = (32'(cfg_i.wdata[pfl_pkg::INIT_W-1:0]) > SLOTS) ? SlotsCnt
               : CW'(cfg_i.wdata[pfl_pkg::INIT_W-1:0]);

  // Sequencer and state update.
  always_comb begin
    state_d    = state_q;
    chunk_d    = chunk_q;
    init_d     = init_q;
    head_d     = head_q;
    free_d     = free_q;
    cap_d      = cap_q;
    grow_d     = grow_q;
    run_ptr_d  = run_ptr_q;
    run_last_d = run_last_q;
    mem_we     = 1'b0;
    mem_waddr  = run_ptr_q;
    mem_wdata  = run_link;
    load_en    = 1'b0;
    load_slot  = '0;
    load_ok    = 1'b1;
    load_free  = free_q;
    load_cap   = cap_q;

    case (state_q)
      ST_INIT: begin
        mem_we = 1'b1;
        if (run_ptr_q == run_last_q) begin
          state_d = ST_IDLE;
        end else begin
          run_ptr_d = run_ptr_q + IW'(1);
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_i.cmd == pfl_pkg::CMD_FREE) begin
            mem_we    = 1'b1;
            mem_waddr = slot_wrap;
            mem_wdata = head_q;
            head_d    = slot_wrap;
            free_d    = free_inc;
            load_en   = 1'b1;
            load_free = free_inc;
          end else if (free_q == '0) begin
            load_en = 1'b1;
            load_ok = 1'b0;
          end else if ((free_q == CW'(1)) && (grow_cnt != '0)) begin
            state_d    = ST_GROW;
            grow_d     = grow_cnt;
            run_ptr_d  = IW'(cap_q);
            run_last_d = IW'(cap_q + grow_cnt - CW'(1));
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        // Pop: the link of the head slot arrived from the memory.
        state_d   = ST_IDLE;
        head_d    = rdata_q;
        free_d    = free_q - CW'(1);
        load_en   = 1'b1;
        load_slot = head_q;
        load_free = free_q - CW'(1);
      end
      ST_GROW: begin
        mem_we = 1'b1;
        if (run_ptr_q == run_last_q) begin
          // The last old slot is granted and the new run becomes the list.
          state_d   = ST_IDLE;
          head_d    = IW'(cap_q);
          cap_d     = cap_q + grow_q;
          free_d    = grow_q;
          load_en   = 1'b1;
          load_slot = head_q;
          load_free = grow_q;
          load_cap  = cap_q + grow_q;
        end else begin
          run_ptr_d = run_ptr_q + IW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Configuration writes; initial_slots restarts the list build.
    if (cfg_acc) begin
      case (cfg_i.idx)
        pfl_pkg::CFG_CHUNK_BYTES: begin
          chunk_d = cfg_i.wdata[ChkW-1:0];
        end
        pfl_pkg::CFG_INITIAL_SLOTS: begin
          init_d     = cfg_i.wdata[pfl_pkg::INIT_W-1:0];
          head_d     = '0;
          free_d     = cfg_n;
          cap_d      = cfg_n;
          run_ptr_d  = '0;
          run_last_d = IW'(cfg_n - CW'(1));
          state_d    = (cfg_n == '0) ? ST_IDLE : ST_INIT;
        end
        default: begin
          chunk_d = chunk_q;
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_INIT;
      chunk_q    <= pfl_pkg::CHUNK_RESET;
      init_q     <= pfl_pkg::INIT_RESET;
      head_q     <= '0;
      free_q     <= CW'(InitN);
      cap_q      <= CW'(InitN);
      grow_q     <= '0;
      run_ptr_q  <= '0;
      run_last_q <= IW'(InitN - 1);
    end else begin
      state_q    <= state_d;
      chunk_q    <= chunk_d;
      init_q     <= init_d;
      head_q     <= head_d;
      free_q     <= free_d;
      cap_q      <= cap_d;
      grow_q     <= grow_d;
      run_ptr_q  <= run_ptr_d;
      run_last_q <= run_last_d;
    end
  end

  // Next-link memory; the read address is always the current head.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= link_mem[head_q];
  end

  // Byte offset of the granted slot.
  assign load_slot8 = SlotW'(load_slot);
  assign load_prod  = (SlotW+ChkW)'(load_slot8) * (SlotW+ChkW)'(chunk_q);

  // Output register: loaded when a result is ready, cleared on transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_en) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en) begin
      out_slot_q <= load_slot8;
      out_off_q  <= OffW'(load_prod);
      out_ok_q   <= load_ok;
      out_free_q <= CntW'(load_free);
      out_cap_q  <= CntW'(load_cap);
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.granted_slot   = out_slot_q;
  assign out_o.granted_offset = out_off_q;
  assign out_o.ok             = out_ok_q;
  assign out_o.free_count     = out_free_q;
  assign out_o.pool_capacity  = out_cap_q;

  // Assertions.
  `PFL_ASSERT_IMP(a_grow_from_one, clk_i, rst_ni, state_q == ST_GROW, free_q == CW'(1))
  `PFL_ASSERT_IMP(a_count_bound, clk_i, rst_ni, 1'b1, (cap_q <= SlotsCnt) && (free_q <= SlotsCnt))
  `PFL_ASSERT_NEXT(a_empty_fails, clk_i, rst_ni, alloc_acc && (free_q == '0), !out_ok_q)
  `PFL_ASSERT_NEXT(a_free_push, clk_i, rst_ni, free_acc, (head_q == $past(slot_wrap)) && out_ok_q)

endmodule

`default_nettype wire
